/* rtl/core/binary_to_decimal_ascii_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII converter
// Shared property wrappers, each clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2da same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2da next-cycle check failed");

`endif

/* rtl/core/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal ASCII converter package
// Stage count, per-stage payload type and the place-value constant helper.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // Ten decimal digits cover any 32-bit value
  localparam int unsigned NUM_DIGITS = 10;
  // One conversion stage per digit above the ones digit
  localparam int unsigned NUM_STAGES = NUM_DIGITS - 1;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;   // index 0 is the ones digit
    logic [31:0]                rem;      // value still to be split
    logic [3:0]                 top;      // index of the first digit sent
    logic                       started;  // first digit already found
  } conv_t;

  // k times ten to the power pos, folded to a constant at each use
  function automatic logic [33:0] place_mult(int unsigned pos, int unsigned k);
    logic [33:0] p;
    p = 34'd1;
    for (int unsigned i = 0; i < pos; i++) begin
      p = p * 34'd10;
    end
    return p * 34'(k);
  endfunction

endpackage

/* rtl/core/binary_to_decimal_ascii.sv */
// An accepted value passes through the digit-extraction stages and then the
// emitter to its first digit beat. Throughput: one digit beat per cycle while
// out_stall_i is low; a value sends 1 to 10 digit beats on the output port. A
// new value enters every cycle while the nine digit-extraction stages have room.
// Reset clears all valid bits, the emitter busy flag and min_digits (to zero).
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Nine-stage digit extraction pipeline followed by a digit emitter that
// sends one ASCII digit per beat, most significant first.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        min_digits_we_i,
  input  logic [3:0]  min_digits_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  ascii_digit_o,
  output logic        is_last_o
);

  logic [3:0]                    min_digits_q;
  logic                          valid_q [NUM_STAGES];
  conv_t                         stage_q [NUM_STAGES];
  logic [NUM_STAGES:0]           stg_ready;
  conv_t                         in_beat;

  logic                          busy_q;
  logic [NUM_DIGITS-1:0][3:0]    digits_q;
  logic [3:0]                    idx_q;
  logic                          emit_ready;
  logic                          emit_load;

  // Hold the padding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_digits_q <= '0;
    end else if (min_digits_we_i) begin
      min_digits_q <= min_digits_i;
    end
  end

  // Wrap the incoming value as a stage payload
  always_comb begin
    in_beat         = '0;
    in_beat.rem     = value_i;
  end

  assign in_stall_o = !stg_ready[0];

  // Extract one digit per stage, from the billions place down to the tens
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam logic [3:0] Pos = 4'(NUM_STAGES - s);

    conv_t src;
    logic  src_vld;
    conv_t stage_d;

    if (s == 0) begin : g_first
      assign src     = in_beat;
      assign src_vld = in_valid_i;
    end else begin : g_next
      assign src     = stage_q[s-1];
      assign src_vld = valid_q[s-1];
    end

    // Compare against all nine multiples, keep the largest that fits
    always_comb begin
      logic [33:0] mult;
      logic [3:0]  q;
      logic [31:0] rem;
      logic        emit;
      q    = '0;
      rem  = src.rem;
      mult = '0;
      for (int k = 1; k <= 9; k++) begin
        mult = place_mult(int'(Pos), k);
        if ({2'b00, src.rem} >= mult) begin
          q   = 4'(k);
          rem = src.rem - mult[31:0];
        end
      end
      emit = (q != '0) || src.started || (min_digits_q > Pos);
      stage_d              = src;
      stage_d.digits[Pos]  = q;
      stage_d.rem          = rem;
      stage_d.started      = src.started || emit;
      if (emit && !src.started) begin
        stage_d.top = Pos;
      end
    end

    // Advance when this stage is empty or the next one takes its beat
    assign stg_ready[s] = !valid_q[s] || stg_ready[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (stg_ready[s]) begin
        valid_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_ready[s] && src_vld) begin
        stage_q[s] <= stage_d;
      end
    end
  end

  // Take a new run when idle or when the last digit leaves this cycle
  assign emit_ready               = !busy_q || (!out_stall_i && (idx_q == '0));
  assign stg_ready[NUM_STAGES]    = emit_ready;
  assign emit_load                = emit_ready && valid_q[NUM_STAGES-1];

  // Emitter control: count down from the first sent digit to the ones digit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (emit_load) begin
      busy_q <= 1'b1;
    end else if (busy_q && !out_stall_i && (idx_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // Emitter payload: load digits with the ones digit from the remainder,
  // step the index on each accepted beat
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      digits_q    <= {stage_q[NUM_STAGES-1].digits[NUM_DIGITS-1:1],
                      stage_q[NUM_STAGES-1].rem[3:0]};
      idx_q       <= stage_q[NUM_STAGES-1].top;
    end else if (busy_q && !out_stall_i) begin
      idx_q       <= idx_q - 4'd1;
    end
  end

  // Drive the digit beat
  assign out_valid_o   = busy_q;
  assign ascii_digit_o = {2'b11, digits_q[idx_q]};
  assign is_last_o     = (idx_q == '0);

endmodule

/* rtl/core/b2da_checker.sv */
// ----------------------------------------------------------------------------
// Decimal ASCII converter checker
// Port-level checks on the digit channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] ascii_digit_o,
  input logic       is_last_o
);

  // Hold a stalled beat
  `B2DA_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `B2DA_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(ascii_digit_o) && $stable(is_last_o))

  // A run never breaks before its last digit
  `B2DA_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_o && !out_stall_i && !is_last_o, out_valid_o)

  // Every beat carries a decimal digit character
  `B2DA_ASSERT_NOW(a_digit_range, clk_i, rst_ni, out_valid_o, ascii_digit_o >= 6'd48 && ascii_digit_o <= 6'd57)

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
